// File: src/cbpc_pkg.sv
package cbpc_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int POS_W          = 32;
  localparam int QUAT_W         = 16;
  localparam int P_W            = 34;
  localparam int MAG_W          = 52;
  localparam int MAG_LIM_BITS   = 30;
  localparam int ACC_W          = 64;
  localparam int DIV_W          = 48;
  localparam int QUO_W          = QUAT_FRAC_BITS + 3;
  localparam int NUM_REGS       = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int IN_DATA_W      = 4 * POS_W + 4 * QUAT_W;
  localparam int OUT_DATA_W     = 3 * POS_W + 4 * QUAT_W;
  localparam int IDX_W          = 5;
  localparam int CNT_W          = 5;

  localparam logic [IDX_W-1:0] IDX_LAST_ROT  = IDX_W'(27);
  localparam logic [IDX_W-1:0] IDX_FIRST_SQ  = IDX_W'(28);
  localparam logic [IDX_W-1:0] IDX_LAST_SQ   = IDX_W'(31);
  localparam logic [CNT_W-1:0] SQRT_LAST     = CNT_W'(31);
  localparam logic [CNT_W-1:0] DIV_LAST      = CNT_W'(QUO_W - 1);

  typedef enum logic [2:0] {
    REG_YAW_COS   = 3'd0,
    REG_YAW_SIN   = 3'd1,
    REG_MOUNT_QX  = 3'd2,
    REG_MOUNT_QY  = 3'd3,
    REG_MOUNT_QZ  = 3'd4,
    REG_MOUNT_QW  = 3'd5,
    REG_YAWFIX_QZ = 3'd6,
    REG_YAWFIX_QW = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_MAG, ST_SHIFT, ST_SQRT,
    ST_DIV_INIT, ST_DIV, ST_DIV_STORE, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    A_X, A_Y, A_QW, A_QZ, A_P0, A_P1, A_P2, A_P3, A_MG0, A_MG1, A_MG2, A_MG3
  } asel_t;

  typedef enum logic [3:0] {
    B_C, B_S, B_CX, B_CY, B_CZ, B_CW, B_M0, B_M1, B_M2, B_M3,
    B_MG0, B_MG1, B_MG2, B_MG3
  } bsel_t;

  typedef enum logic [3:0] {
    D_NONE, D_BX, D_BY, D_P0, D_P1, D_P2, D_P3, D_R0, D_R1, D_R2, D_R3, D_SUM
  } dest_t;

  typedef struct packed {
    asel_t a;
    bsel_t b;
    logic  neg;
    dest_t dest;
  } prod_op_t;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic             acc;
    logic [IDX_W-1:0] idx;
    logic             mag;
    logic             shift;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             div_store;
    logic [1:0]       comp;
    logic             out_load;
  } cbpc_cmd_t;

  typedef struct packed {
    logic stamp_new;
    logic mx_zero;
    logic mx_big;
    logic out_free;
  } cbpc_stat_t;

  // Product schedule: rotation, yaw-fix times camera, that times mount, squares.
  function automatic prod_op_t prod_op(input logic [IDX_W-1:0] idx);
    prod_op_t op;
    case (idx)
      5'd0:  op = '{A_X,   B_C,   1'b0, D_NONE};
      5'd1:  op = '{A_Y,   B_S,   1'b0, D_BX};
      5'd2:  op = '{A_X,   B_S,   1'b1, D_NONE};
      5'd3:  op = '{A_Y,   B_C,   1'b0, D_BY};
      5'd4:  op = '{A_QW,  B_CX,  1'b0, D_NONE};
      5'd5:  op = '{A_QZ,  B_CY,  1'b1, D_P0};
      5'd6:  op = '{A_QW,  B_CY,  1'b0, D_NONE};
      5'd7:  op = '{A_QZ,  B_CX,  1'b0, D_P1};
      5'd8:  op = '{A_QW,  B_CZ,  1'b0, D_NONE};
      5'd9:  op = '{A_QZ,  B_CW,  1'b0, D_P2};
      5'd10: op = '{A_QW,  B_CW,  1'b0, D_NONE};
      5'd11: op = '{A_QZ,  B_CZ,  1'b1, D_P3};
      5'd12: op = '{A_P3,  B_M0,  1'b0, D_NONE};
      5'd13: op = '{A_P0,  B_M3,  1'b0, D_NONE};
      5'd14: op = '{A_P1,  B_M2,  1'b0, D_NONE};
      5'd15: op = '{A_P2,  B_M1,  1'b1, D_R0};
      5'd16: op = '{A_P3,  B_M1,  1'b0, D_NONE};
      5'd17: op = '{A_P0,  B_M2,  1'b1, D_NONE};
      5'd18: op = '{A_P1,  B_M3,  1'b0, D_NONE};
      5'd19: op = '{A_P2,  B_M0,  1'b0, D_R1};
      5'd20: op = '{A_P3,  B_M2,  1'b0, D_NONE};
      5'd21: op = '{A_P0,  B_M1,  1'b0, D_NONE};
      5'd22: op = '{A_P1,  B_M0,  1'b1, D_NONE};
      5'd23: op = '{A_P2,  B_M3,  1'b0, D_R2};
      5'd24: op = '{A_P3,  B_M3,  1'b0, D_NONE};
      5'd25: op = '{A_P0,  B_M0,  1'b1, D_NONE};
      5'd26: op = '{A_P1,  B_M1,  1'b1, D_NONE};
      5'd27: op = '{A_P2,  B_M2,  1'b1, D_R3};
      5'd28: op = '{A_MG0, B_MG0, 1'b0, D_NONE};
      5'd29: op = '{A_MG1, B_MG1, 1'b0, D_NONE};
      5'd30: op = '{A_MG2, B_MG2, 1'b0, D_NONE};
      5'd31: op = '{A_MG3, B_MG3, 1'b0, D_SUM};
      default: op = '{A_X, B_C, 1'b0, D_NONE};
    endcase
    return op;
  endfunction

endpackage

// File: src/cbpc_ctrl.sv
module cbpc_ctrl
  import cbpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  cbpc_stat_t stat,
  output cbpc_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       comp_r, comp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && stat.stamp_new) begin
          state_nxt = ST_MUL;
          idx_nxt   = '0;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (idx_r == IDX_LAST_ROT) begin
          state_nxt = ST_MAG;
        end else if (idx_r == IDX_LAST_SQ) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_MUL;
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end
      ST_MAG: state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (stat.mx_zero) begin
          state_nxt = ST_DONE;
        end else if (!stat.mx_big) begin
          state_nxt = ST_MUL;
          idx_nxt   = IDX_FIRST_SQ;
        end
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_DIV_INIT;
          comp_nxt  = '0;
        end
      end
      ST_DIV_INIT: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        if (comp_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.comp  = comp_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid && stat.stamp_new;
      end
      ST_MUL:       cmd.mul       = 1'b1;
      ST_ACC:       cmd.acc       = 1'b1;
      ST_MAG:       cmd.mag       = 1'b1;
      ST_SHIFT:     cmd.shift     = !stat.mx_zero && stat.mx_big;
      ST_SQRT:      cmd.sqrt_step = 1'b1;
      ST_DIV_INIT:  cmd.div_init  = 1'b1;
      ST_DIV:       cmd.div_step  = 1'b1;
      ST_DIV_STORE: cmd.div_store = 1'b1;
      ST_DONE:      cmd.out_load  = stat.out_free;
      default:      cmd           = '0;
    endcase
  end

endmodule

// File: src/cbpc_datapath.sv
module cbpc_datapath
  import cbpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [QUAT_W-1:0]     cfg_data,
  input  cbpc_cmd_t             cmd,
  output cbpc_stat_t            stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic signed [QUAT_W-1:0] reg_r [NUM_REGS];
  logic [POS_W-1:0]         newest_r;

  logic signed [POS_W-1:0]  x_r, y_r, z_r;
  logic signed [QUAT_W-1:0] cq_r [4];
  logic signed [P_W-1:0]    p_r [4];
  logic signed [MAG_W-1:0]  r_r [4];
  logic [MAG_W-1:0]         mag_r [4];
  logic [MAG_W-1:0]         mx_r;
  logic signed [ACC_W-1:0]  prod_r, acc_r, bx_r, by_r;
  logic [ACC_W-1:0]         v_r, res_r, bit_r;
  logic [DIV_W-1:0]         rem_r, d_r;
  logic [QUO_W-1:0]         q_r;
  logic signed [QUAT_W-1:0] o_r [4];
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  prod_op_t                 op;
  logic signed [P_W-1:0]    opa;
  logic signed [POS_W-1:0]  opb;
  logic signed [ACC_W-1:0]  accv;
  logic [MAG_W-1:0]         absv [4];
  logic [MAG_W-1:0]         mx01, mx23;
  logic [ACC_W-1:0]         sq_t;
  logic [POS_W-1:0]         root;
  logic [POS_W-1:0]         bx_sat, by_sat;

  assign op = prod_op(cmd.idx);

  always_comb begin
    case (op.a)
      A_X:     opa = P_W'(x_r);
      A_Y:     opa = P_W'(y_r);
      A_QW:    opa = P_W'(reg_r[REG_YAWFIX_QW]);
      A_QZ:    opa = P_W'(reg_r[REG_YAWFIX_QZ]);
      A_P0:    opa = p_r[0];
      A_P1:    opa = p_r[1];
      A_P2:    opa = p_r[2];
      A_P3:    opa = p_r[3];
      A_MG0:   opa = signed'(P_W'(mag_r[0][MAG_LIM_BITS-1:0]));
      A_MG1:   opa = signed'(P_W'(mag_r[1][MAG_LIM_BITS-1:0]));
      A_MG2:   opa = signed'(P_W'(mag_r[2][MAG_LIM_BITS-1:0]));
      A_MG3:   opa = signed'(P_W'(mag_r[3][MAG_LIM_BITS-1:0]));
      default: opa = '0;
    endcase
    case (op.b)
      B_C:     opb = POS_W'(reg_r[REG_YAW_COS]);
      B_S:     opb = POS_W'(reg_r[REG_YAW_SIN]);
      B_CX:    opb = POS_W'(cq_r[0]);
      B_CY:    opb = POS_W'(cq_r[1]);
      B_CZ:    opb = POS_W'(cq_r[2]);
      B_CW:    opb = POS_W'(cq_r[3]);
      B_M0:    opb = POS_W'(reg_r[REG_MOUNT_QX]);
      B_M1:    opb = POS_W'(reg_r[REG_MOUNT_QY]);
      B_M2:    opb = POS_W'(reg_r[REG_MOUNT_QZ]);
      B_M3:    opb = POS_W'(reg_r[REG_MOUNT_QW]);
      B_MG0:   opb = signed'(POS_W'(mag_r[0][MAG_LIM_BITS-1:0]));
      B_MG1:   opb = signed'(POS_W'(mag_r[1][MAG_LIM_BITS-1:0]));
      B_MG2:   opb = signed'(POS_W'(mag_r[2][MAG_LIM_BITS-1:0]));
      B_MG3:   opb = signed'(POS_W'(mag_r[3][MAG_LIM_BITS-1:0]));
      default: opb = '0;
    endcase
  end

  assign accv = op.neg ? acc_r - prod_r : acc_r + prod_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      absv[i] = r_r[i][MAG_W-1] ? MAG_W'(-r_r[i]) : MAG_W'(r_r[i]);
    end
    mx01 = (absv[0] > absv[1]) ? absv[0] : absv[1];
    mx23 = (absv[2] > absv[3]) ? absv[2] : absv[3];
  end

  assign sq_t = res_r + bit_r;
  assign root = res_r[POS_W-1:0];

  function automatic logic [POS_W-1:0] pos_round(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + (ACC_W'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
    if (t > ACC_W'(32'sh7FFF_FFFF)) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (t < -(ACC_W'(1) <<< (POS_W - 1))) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end
    return t[POS_W-1:0];
  endfunction

  assign bx_sat = pos_round(bx_r);
  assign by_sat = pos_round(by_r);

  // Configuration registers and the newest accepted stamp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r[REG_YAW_COS]   <= 16'sd0;
      reg_r[REG_YAW_SIN]   <= -16'sd16384;
      reg_r[REG_MOUNT_QX]  <= 16'sd0;
      reg_r[REG_MOUNT_QY]  <= 16'sd0;
      reg_r[REG_MOUNT_QZ]  <= 16'sd11585;
      reg_r[REG_MOUNT_QW]  <= 16'sd11585;
      reg_r[REG_YAWFIX_QZ] <= 16'sd11585;
      reg_r[REG_YAWFIX_QW] <= 16'sd11585;
      newest_r             <= '0;
    end else begin
      if (cfg_valid) begin
        reg_r[cfg_index] <= cfg_data;
      end
      if (cmd.load) begin
        newest_r <= in_tdata[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_tdata[2*POS_W-1:POS_W];
      y_r   <= in_tdata[3*POS_W-1:2*POS_W];
      z_r   <= in_tdata[4*POS_W-1:3*POS_W];
      for (int i = 0; i < 4; i++) begin
        cq_r[i] <= in_tdata[4*POS_W + i*QUAT_W +: QUAT_W];
      end
      acc_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= ACC_W'(opa * opb);
    end
    if (cmd.acc) begin
      acc_r <= (op.dest == D_NONE) ? accv : '0;
      case (op.dest)
        D_BX: bx_r    <= accv;
        D_BY: by_r    <= accv;
        D_P0: p_r[0]  <= P_W'(accv);
        D_P1: p_r[1]  <= P_W'(accv);
        D_P2: p_r[2]  <= P_W'(accv);
        D_P3: p_r[3]  <= P_W'(accv);
        D_R0: r_r[0]  <= MAG_W'(accv);
        D_R1: r_r[1]  <= MAG_W'(accv);
        D_R2: r_r[2]  <= MAG_W'(accv);
        D_R3: r_r[3]  <= MAG_W'(accv);
        D_SUM: begin
          v_r   <= accv;
          res_r <= '0;
          bit_r <= ACC_W'(1) << (ACC_W - 2);
        end
        default: ;
      endcase
    end
    if (cmd.mag) begin
      for (int i = 0; i < 4; i++) begin
        mag_r[i] <= absv[i];
        o_r[i]   <= '0;
      end
      mx_r <= (mx01 > mx23) ? mx01 : mx23;
    end
    if (cmd.shift) begin
      for (int i = 0; i < 4; i++) begin
        mag_r[i] <= mag_r[i] >> 1;
      end
      mx_r <= mx_r >> 1;
    end
    // One digit of the integer square root per cycle.
    if (cmd.sqrt_step) begin
      if (v_r >= sq_t) begin
        v_r   <= v_r - sq_t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      rem_r <= (DIV_W'(mag_r[cmd.comp][MAG_LIM_BITS-1:0]) << QUAT_FRAC_BITS)
               + DIV_W'(root >> 1);
      d_r   <= DIV_W'(root) << (QUO_W - 1);
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= d_r) begin
        rem_r <= rem_r - d_r;
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
      d_r <= d_r >> 1;
    end
    if (cmd.div_store) begin
      if (r_r[cmd.comp][MAG_W-1]) begin
        o_r[cmd.comp] <= (q_r > QUO_W'(32768)) ? {1'b1, {(QUAT_W-1){1'b0}}}
                                               : QUAT_W'(-q_r);
      end else begin
        o_r[cmd.comp] <= (q_r > QUO_W'(32767)) ? {1'b0, {(QUAT_W-1){1'b1}}}
                                               : QUAT_W'(q_r);
      end
    end
    if (cmd.out_load) begin
      out_data_r <= {o_r[3], o_r[2], o_r[1], o_r[0], z_r, by_sat, bx_sat};
    end
  end

  // The output register lets the next request in while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.stamp_new = in_tdata[POS_W-1:0] > newest_r;
  assign stat.mx_zero   = (mx_r == '0);
  assign stat.mx_big    = |mx_r[MAG_W-1:MAG_LIM_BITS];
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/camera_to_body_pose_conversion_top.sv
// Camera pose to body pose converter. Each request carries a stamp, a Q16.16
// position and a Q2.14 quaternion; a request whose stamp is not newer than the
// last one taken is dropped without a result. Otherwise x and y are rotated by
// the world yaw, z passes through, and the orientation becomes the normalised
// product of the yaw-fix, camera and mount quaternions. Each accepted request
// runs in order: 28 products through the one shared 34 x 32 multiplier, the
// magnitude, a magnitude reduction by right shifts, four squares, a bit-serial
// square root and four restoring divisions, then the output hand-over. A zero
// product skips the squares, square root and divisions and gives a zero
// orientation. A new request is taken while the previous result waits in the
// output register; configuration is taken on every cycle.
module camera_to_body_pose_conversion_top
  import cbpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // stamp, cam_x, cam_y, cam_z, cam_qx, cam_qy, cam_qz, cam_qw (lowest first)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // body_x, body_y, body_z, body_qx, body_qy, body_qz, body_qw (lowest first)
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [QUAT_W-1:0]     cfg_data
);

  cbpc_cmd_t  cmd;
  cbpc_stat_t stat;

  assign cfg_ready = 1'b1;

  cbpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cbpc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: src/cbpc_checker.sv
module cbpc_checker
  import cbpc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // A result is only ever loaded while the block is busy finishing a request.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a request in progress");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port blocked");

endmodule

bind camera_to_body_pose_conversion_top cbpc_checker u_cbpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
